>>> hdl/jqz_pkg.sv
// Shared constants and types for the quantize and zigzag block.
package jqz_pkg;

  localparam int DIV_WIDTH   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

>>> hdl/jqz_in_if.sv
// Input channel: one raster coefficient and its divisor per beat.
interface jqz_in_if import jqz_pkg::*; #(
  parameter int COEF_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coefficient;
  logic [DIV_WIDTH-1:0]         quant_divisor;

  modport source (output valid, coefficient, quant_divisor, input ready);
  modport sink   (input valid, coefficient, quant_divisor, output ready);
endinterface

>>> hdl/jqz_out_if.sv
// Result channel: one zigzag-ordered quotient per beat.
interface jqz_out_if #(
  parameter int COEF_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] quantized_value;
  logic                         last_of_block;

  modport source (output valid, quantized_value, last_of_block, input ready);
  modport sink   (input valid, quantized_value, last_of_block, output ready);
endinterface

>>> hdl/jqz_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jqz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/jqz_front.sv
// Front end: accepts beats, tags raster position and end of block, queues them.
module jqz_front import jqz_pkg::*; #(
  parameter int BLOCK_SIDE = 8,
  parameter int COEF_WIDTH = 16,
  localparam int AREA      = BLOCK_SIDE * BLOCK_SIDE,
  localparam int ADDR_W    = $clog2(AREA)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  jqz_in_if.sink                       in_ch,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic signed [COEF_WIDTH-1:0] q_coef,
  output logic [DIV_WIDTH-1:0]         q_div,
  output logic [ADDR_W-1:0]            q_pos,
  output logic                         q_last
);

  logic [ADDR_W-1:0]            load_count_r, load_count_nxt;
  logic                         pos_last;
  logic                         push, pop;
  logic [QPTR_W-1:0]            wp_r, rp_r;
  logic [QCNT_W-1:0]            cnt_r;
  logic signed [COEF_WIDTH-1:0] qe_coef_r [QUEUE_DEPTH];
  logic [DIV_WIDTH-1:0]         qe_div_r  [QUEUE_DEPTH];
  logic [ADDR_W-1:0]            qe_pos_r  [QUEUE_DEPTH];
  logic                         qe_last_r [QUEUE_DEPTH];

  assign in_ch.ready    = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push           = in_ch.valid && in_ch.ready;
  assign pop            = q_valid && q_ready;
  assign pos_last       = (load_count_r == ADDR_W'(AREA - 1));
  assign load_count_nxt = pos_last ? '0 : load_count_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      cnt_r        <= '0;
    end else begin
      if (push) begin
        load_count_r <= load_count_nxt;
        wp_r         <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qe_coef_r[wp_r] <= in_ch.coefficient;
      qe_div_r[wp_r]  <= in_ch.quant_divisor;
      qe_pos_r[wp_r]  <= load_count_r;
      qe_last_r[wp_r] <= pos_last;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_coef  = qe_coef_r[rp_r];
  assign q_div   = qe_div_r[rp_r];
  assign q_pos   = qe_pos_r[rp_r];
  assign q_last  = qe_last_r[rp_r];

endmodule

>>> hdl/jqz_div.sv
// Pipelined signed divider, one restoring quotient bit per stage, truncating toward zero.
module jqz_div import jqz_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int ADDR_W     = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COEF_WIDTH-1:0] in_coef,
  input  logic [DIV_WIDTH-1:0]         in_div,
  input  logic [ADDR_W-1:0]            in_pos,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic signed [COEF_WIDTH-1:0] out_quot,
  output logic [ADDR_W-1:0]            out_pos,
  output logic                         out_last
);

  localparam int N = COEF_WIDTH;

  logic                  s_valid_r [N+1];
  logic                  s_neg_r   [N+1];
  logic [COEF_WIDTH-1:0] s_dq_r    [N+1];
  logic [DIV_WIDTH-1:0]  s_rem_r   [N+1];
  logic [DIV_WIDTH-1:0]  s_div_r   [N+1];
  logic [ADDR_W-1:0]     s_pos_r   [N+1];
  logic                  s_last_r  [N+1];

  logic [COEF_WIDTH-1:0] coef_u;
  logic [COEF_WIDTH-1:0] mag;
  logic [DIV_WIDTH-1:0]  div_fix;

  assign coef_u  = in_coef;
  assign mag     = coef_u[COEF_WIDTH-1] ? (~coef_u + COEF_WIDTH'(1)) : coef_u;
  assign div_fix = (in_div == '0) ? DIV_WIDTH'(1) : in_div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r[0] <= 1'b0;
    end else begin
      s_valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_neg_r[0]  <= coef_u[COEF_WIDTH-1];
    s_dq_r[0]   <= mag;
    s_rem_r[0]  <= '0;
    s_div_r[0]  <= div_fix;
    s_pos_r[0]  <= in_pos;
    s_last_r[0] <= in_last;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DIV_WIDTH:0]    trial;
    logic                  ge;
    logic [DIV_WIDTH-1:0]  rem_nxt;
    logic [COEF_WIDTH-1:0] dq_nxt;

    assign trial   = {s_rem_r[i], s_dq_r[i][COEF_WIDTH-1]};
    assign ge      = (trial >= {1'b0, s_div_r[i]});
    assign rem_nxt = ge ? DIV_WIDTH'(trial - {1'b0, s_div_r[i]}) : DIV_WIDTH'(trial);
    assign dq_nxt  = {s_dq_r[i][COEF_WIDTH-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_valid_r[i+1] <= 1'b0;
      end else begin
        s_valid_r[i+1] <= s_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      s_neg_r[i+1]  <= s_neg_r[i];
      s_dq_r[i+1]   <= dq_nxt;
      s_rem_r[i+1]  <= rem_nxt;
      s_div_r[i+1]  <= s_div_r[i];
      s_pos_r[i+1]  <= s_pos_r[i];
      s_last_r[i+1] <= s_last_r[i];
    end
  end

  assign out_valid = s_valid_r[N];
  assign out_quot  = s_neg_r[N] ? (~s_dq_r[N] + COEF_WIDTH'(1)) : s_dq_r[N];
  assign out_pos   = s_pos_r[N];
  assign out_last  = s_last_r[N];

endmodule

>>> hdl/jqz_back.sv
// Back end: divides queued beats into the block buffer, then reads it out in zigzag order.
module jqz_back import jqz_pkg::*; #(
  parameter int BLOCK_SIDE = 8,
  parameter int COEF_WIDTH = 16,
  localparam int AREA      = BLOCK_SIDE * BLOCK_SIDE,
  localparam int ADDR_W    = $clog2(AREA)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic signed [COEF_WIDTH-1:0] q_coef,
  input  logic [DIV_WIDTH-1:0]         q_div,
  input  logic [ADDR_W-1:0]            q_pos,
  input  logic                         q_last,
  jqz_out_if.source                    out_ch
);

  localparam int RC_W = $clog2(BLOCK_SIDE);
  localparam logic [RC_W-1:0] EDGE = RC_W'(BLOCK_SIDE - 1);

  function automatic logic [2*RC_W-1:0] zz_next(input logic [RC_W-1:0] r,
                                                input logic [RC_W-1:0] c);
    logic [RC_W-1:0] rn;
    logic [RC_W-1:0] cn;
    rn = r;
    cn = c;
    if (r[0] == c[0]) begin
      if (r == '0) begin
        if (c != EDGE) cn = c + RC_W'(1);
        else           rn = r + RC_W'(1);
      end else if (c == EDGE) begin
        rn = r + RC_W'(1);
      end else begin
        cn = c + RC_W'(1);
        rn = r - RC_W'(1);
      end
    end else begin
      if (c == '0) begin
        if (r != EDGE) rn = r + RC_W'(1);
        else           cn = c + RC_W'(1);
      end else if (r == EDGE) begin
        cn = c + RC_W'(1);
      end else begin
        cn = c - RC_W'(1);
        rn = r + RC_W'(1);
      end
    end
    return {rn, cn};
  endfunction

  back_state_t state_r, state_nxt;

  logic                         q_pop;
  logic                         dv_valid;
  logic signed [COEF_WIDTH-1:0] dv_quot;
  logic [ADDR_W-1:0]            dv_pos;
  logic                         dv_last;

  logic [RC_W-1:0]       row_r, col_r;
  logic [2*RC_W-1:0]     zz_nxt;
  logic [ADDR_W-1:0]     emit_cnt_r;
  logic                  emit_last;
  logic                  rd_issue;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COEF_WIDTH-1:0] rd_data;
  logic                  inflight_r, inflight_last_r;

  logic [COEF_WIDTH-1:0] ob_data_r [2];
  logic                  ob_last_r [2];
  logic                  ob_wp_r, ob_rp_r;
  logic [1:0]            ob_cnt_r;
  logic [1:0]            occ;
  logic                  ob_pop;

  assign q_pop = q_valid && q_ready;

  jqz_div #(
    .COEF_WIDTH (COEF_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop),
    .in_coef   (q_coef),
    .in_div    (q_div),
    .in_pos    (q_pos),
    .in_last   (q_last),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_pos   (dv_pos),
    .out_last  (dv_last)
  );

  jqz_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (AREA)
  ) u_buf (
    .clk     (clk),
    .wr_en   (dv_valid),
    .wr_addr (dv_pos),
    .wr_data (dv_quot),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ob_pop    = out_ch.valid && out_ch.ready;
  assign occ       = ob_cnt_r + {1'b0, inflight_r};
  assign emit_last = (emit_cnt_r == ADDR_W'(AREA - 1));
  assign rd_addr   = ADDR_W'(row_r) * ADDR_W'(BLOCK_SIDE) + ADDR_W'(col_r);
  assign zz_nxt    = zz_next(row_r, col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    rd_issue  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid && q_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (dv_valid && dv_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        rd_issue = (occ != 2'd2) || ob_pop;
        if (rd_issue && emit_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r           <= '0;
      col_r           <= '0;
      emit_cnt_r      <= '0;
      inflight_r      <= 1'b0;
      inflight_last_r <= 1'b0;
      ob_wp_r         <= 1'b0;
      ob_rp_r         <= 1'b0;
      ob_cnt_r        <= '0;
    end else begin
      if (state_r != ST_EMIT) begin
        row_r      <= '0;
        col_r      <= '0;
        emit_cnt_r <= '0;
      end else if (rd_issue) begin
        {row_r, col_r} <= zz_nxt;
        emit_cnt_r     <= emit_cnt_r + ADDR_W'(1);
      end
      inflight_r      <= rd_issue;
      inflight_last_r <= rd_issue && emit_last;
      if (inflight_r) ob_wp_r <= ~ob_wp_r;
      if (ob_pop)     ob_rp_r <= ~ob_rp_r;
      ob_cnt_r <= ob_cnt_r + 2'(inflight_r) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (inflight_r) begin
      ob_data_r[ob_wp_r] <= rd_data;
      ob_last_r[ob_wp_r] <= inflight_last_r;
    end
  end

  assign out_ch.valid           = (ob_cnt_r != '0);
  assign out_ch.quantized_value = ob_data_r[ob_rp_r];
  assign out_ch.last_of_block   = ob_last_r[ob_rp_r];

endmodule

>>> hdl/jpeg_quantize_zigzag.sv
// Top level: JPEG quantization with zigzag reorder of one square block.
//
//  channel  dir  beat                              handshake
//  in_ch    in   coefficient, quant_divisor        valid/ready
//  out_ch   out  quantized_value, last_of_block    valid/ready
//
// Loading moves one beat per cycle while the back end is in ST_LOAD,
// through a 4-deep queue into a divider pipeline of COEF_WIDTH+1
// stages; after the last beat of a block drains, BLOCK_SIDE^2 reads of
// the buffer RAM go out one per cycle while the output buffer has room.
// Synchronous reset clears control only; no buffer clearing pass.
// The queue takes at most 4 beats of the next block during readout.
module jpeg_quantize_zigzag import jqz_pkg::*; #(
  parameter int BLOCK_SIDE = 8,
  parameter int COEF_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  jqz_in_if.sink    in_ch,
  jqz_out_if.source out_ch
);

  localparam int AREA   = BLOCK_SIDE * BLOCK_SIDE;
  localparam int ADDR_W = $clog2(AREA);

  logic                         q_valid;
  logic                         q_ready;
  logic signed [COEF_WIDTH-1:0] q_coef;
  logic [DIV_WIDTH-1:0]         q_div;
  logic [ADDR_W-1:0]            q_pos;
  logic                         q_last;

  jqz_front #(
    .BLOCK_SIDE (BLOCK_SIDE),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_coef  (q_coef),
    .q_div   (q_div),
    .q_pos   (q_pos),
    .q_last  (q_last)
  );

  jqz_back #(
    .BLOCK_SIDE (BLOCK_SIDE),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_coef  (q_coef),
    .q_div   (q_div),
    .q_pos   (q_pos),
    .q_last  (q_last),
    .out_ch  (out_ch)
  );

endmodule

>>> test/jqz_zigzag_checker.sv
// Scoreboard for the quantize and zigzag block: predicts zigzag quotients and checks each beat.
module jqz_zigzag_checker import jqz_pkg::*; #(
  parameter int BLOCK_SIDE = 8,
  parameter int COEF_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  jqz_in_if    in_ch,
  jqz_out_if   out_ch,
  output int   fail_count,
  output int   expected_left,
  output int   beats_checked,
  output int   blocks_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AREA = BLOCK_SIDE * BLOCK_SIDE;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] value;
    logic                         last;
  } zz_beat_t;

  logic signed [COEF_WIDTH-1:0] raster_quot [AREA];
  int                           zigzag_raster [AREA];
  int                           load_pos;
  zz_beat_t                     zigzag_expected [$];

  function automatic logic signed [COEF_WIDTH-1:0] quantize(
    input logic signed [COEF_WIDTH-1:0] coef,
    input logic [DIV_WIDTH-1:0]         divisor
  );
    int d;
    // zero divisor acts as one
    d = (divisor == '0) ? 1 : int'(divisor);
    return COEF_WIDTH'(int'(coef) / d);
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t %s", $realtime, msg);
  endfunction

  initial begin
    int n;
    int lo;
    int hi;
    fail_count     = 0;
    expected_left  = 0;
    beats_checked  = 0;
    blocks_checked = 0;
    load_pos       = 0;
    n              = 0;
    // walk the anti-diagonals; even ones run bottom-left to top-right
    for (int s = 0; s <= 2 * BLOCK_SIDE - 2; s++) begin
      lo = (s < BLOCK_SIDE) ? 0 : s - BLOCK_SIDE + 1;
      hi = (s < BLOCK_SIDE) ? s : BLOCK_SIDE - 1;
      if (s % 2 == 0) begin
        for (int r = hi; r >= lo; r--) begin
          zigzag_raster[n] = r * BLOCK_SIDE + (s - r);
          n++;
        end
      end else begin
        for (int r = lo; r <= hi; r++) begin
          zigzag_raster[n] = r * BLOCK_SIDE + (s - r);
          n++;
        end
      end
    end
  end

  always @(posedge clk) begin
    zz_beat_t got;
    zz_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.quantized_value, out_ch.last_of_block};
        beats_checked++;
        if (zigzag_expected.size() == 0) begin
          log_failure($sformatf("unexpected beat: value %0d last %0b", got.value, got.last));
        end else begin
          want = zigzag_expected.pop_front();
          if (got !== want)
            log_failure($sformatf("beat %0d mismatch: expected value %0d last %0b, got %0d last %0b",
                                  beats_checked, want.value, want.last, got.value, got.last));
          if (want.last) blocks_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        raster_quot[load_pos] = quantize(in_ch.coefficient, in_ch.quant_divisor);
        if (load_pos == AREA - 1) begin
          for (int k = 0; k < AREA; k++)
            zigzag_expected.push_back('{raster_quot[zigzag_raster[k]], k == AREA - 1});
          load_pos = 0;
        end else begin
          load_pos++;
        end
      end
    end
    expected_left = zigzag_expected.size();
  end

endmodule

>>> test/jpeg_quantize_zigzag_tb.sv
// Testbench top for the quantize and zigzag block: drives coefficient blocks and gives the verdict.
module jpeg_quantize_zigzag_tb import jqz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_SIDE    = 8;
  localparam int COEF_WIDTH    = 16;
  localparam int AREA          = BLOCK_SIDE * BLOCK_SIDE;
  localparam int RANDOM_BLOCKS = 4;
  localparam int N_DIRECTED    = 20;

  localparam logic signed [COEF_WIDTH-1:0] DIR_COEF [N_DIRECTED] = '{
    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0,
    -16'sd1,   16'sd1,    -16'sd7,   16'sd7,    16'sh8000,
    16'sd12345, -16'sd255, -16'sd254, 16'sd100, -16'sd100,
    -16'sd32767, 16'sh7fff, 16'sh5555, 16'shaaaa, -16'sd1
  };
  localparam logic [DIV_WIDTH-1:0] DIR_DIV [N_DIRECTED] = '{
    8'd1,   8'd1,   8'd255, 8'd255, 8'd7,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd0,
    8'd0,   8'd255, 8'd255, 8'd3,   8'd3,
    8'd128, 8'd128, 8'haa,  8'h55,  8'd1
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   steady;
  int   sent_count;
  int   zero_div_count;
  int   fail_count;
  int   expected_left;
  int   beats_checked;
  int   blocks_checked;

  jqz_in_if  #(.COEF_WIDTH(COEF_WIDTH)) in_ch ();
  jqz_out_if #(.COEF_WIDTH(COEF_WIDTH)) out_ch ();

  jpeg_quantize_zigzag #(
    .BLOCK_SIDE(BLOCK_SIDE),
    .COEF_WIDTH(COEF_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  jqz_zigzag_checker #(
    .BLOCK_SIDE(BLOCK_SIDE),
    .COEF_WIDTH(COEF_WIDTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .beats_checked (beats_checked),
    .blocks_checked(blocks_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 12);
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [COEF_WIDTH-1:0] pick_coef();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return COEF_WIDTH'(int'($urandom_range(200)) - 100);
    if (roll < 75) return COEF_WIDTH'($urandom);
    if (roll < 90) return COEF_WIDTH'(int'($urandom_range(4095)) - 2048);
    case ($urandom_range(3))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [DIV_WIDTH-1:0] pick_div();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5)  return '0;
    if (roll < 15) return 8'd1;
    if (roll < 20) return 8'd255;
    return DIV_WIDTH'($urandom_range(255, 1));
  endfunction

  task automatic send_beat(input logic signed [COEF_WIDTH-1:0] coef,
                           input logic [DIV_WIDTH-1:0] divisor);
    while (!steady && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.coefficient   <= coef;
    in_ch.quant_divisor <= divisor;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (divisor == '0) zero_div_count++;
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.coefficient   = '0;
    in_ch.quant_divisor = 8'd1;
    out_ch.ready        = 1'b0;
    steady              = 1'b0;
    sent_count          = 0;
    zero_div_count      = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, truncation of negatives, zero divisor
    for (int i = 0; i < N_DIRECTED; i++) send_beat(DIR_COEF[i], DIR_DIV[i]);
    for (int i = N_DIRECTED; i < AREA; i++) send_beat(pick_coef(), pick_div());

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      steady = (b == 1);
      for (int i = 0; i < AREA; i++) send_beat(pick_coef(), pick_div());
      if (b == 2) begin
        in_ch.valid <= 1'b0;
        while (expected_left != 0) @(negedge clk);
      end
    end
    steady = 1'b0;

    // partial block left loading at the end
    repeat (9) send_beat(pick_coef(), pick_div());
    in_ch.valid <= 1'b0;

    while (expected_left != 0) @(negedge clk);
    repeat (3 * AREA) @(negedge clk);

    $display("Sent %0d coefficients (%0d with zero divisor), checked %0d quotients in %0d blocks.",
             sent_count, zero_div_count, beats_checked, blocks_checked);
    $display("Mismatches or stray beats: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
